// ===== sv/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg: orbit camera controller shared definitions
// Field widths, fixed-point constants, operation codes and the arctangent
// table used by the CORDIC unit.
// ----------------------------------------------------------------------------
package occ_pkg;

    // word field widths
    localparam int FUNC_W   = 2;
    localparam int OFFSET_W = 24;
    localparam int STICK_W  = 16;
    localparam int YAW_W    = 15;
    localparam int PITCH_W  = 14;
    localparam int DIST_W   = 24;
    localparam int FOCUS_W  = 32;
    localparam int DZ_W     = 15;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int TRIG_W   = 18;   // sine / cosine, Q.16

    // operation codes
    localparam logic [FUNC_W-1:0] OP_SPIN = 2'd0;
    localparam logic [FUNC_W-1:0] OP_RISE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_ZOOM = 2'd2;
    localparam logic [FUNC_W-1:0] OP_MOVE = 2'd3;

    // configuration register indexes
    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_MOVE_GAIN = 1'b1;

    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 15'd8192;
    localparam logic [GAIN_W-1:0] MOVE_GAIN_RST = 16'd983;

    // angles: 1/2^ANGLE_FRAC_BITS degree
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
    localparam int PITCH_LOW       = -(90 << ANGLE_FRAC_BITS);
    localparam int ANG_Q22_SHIFT   = 22 - ANGLE_FRAC_BITS;
    localparam int DEG_Q22_90      = 90 << 22;
    localparam int DEG_Q22_180     = 180 << 22;
    localparam int DIST_MAX        = 16777215;

    localparam int TRIG_ITER_DEF   = 16;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    typedef struct packed {
        logic                      done;
        logic signed [TRIG_W-1:0]  sin_q16;
        logic signed [TRIG_W-1:0]  cos_q16;
    } t_trig;

    // atan(2^-i) in degrees, Q.22
    function automatic logic signed [31:0] atan_q22(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd188743680;
            5'd1:    v = 32'sd111421900;
            5'd2:    v = 32'sd58872272;
            5'd3:    v = 32'sd29884485;
            5'd4:    v = 32'sd15000234;
            5'd5:    v = 32'sd7507429;
            5'd6:    v = 32'sd3754631;
            5'd7:    v = 32'sd1877430;
            5'd8:    v = 32'sd938729;
            5'd9:    v = 32'sd469366;
            5'd10:   v = 32'sd234683;
            5'd11:   v = 32'sd117342;
            5'd12:   v = 32'sd58671;
            5'd13:   v = 32'sd29335;
            5'd14:   v = 32'sd14668;
            5'd15:   v = 32'sd7334;
            5'd16:   v = 32'sd3667;
            5'd17:   v = 32'sd1833;
            5'd18:   v = 32'sd917;
            5'd19:   v = 32'sd458;
            5'd20:   v = 32'sd229;
            5'd21:   v = 32'sd115;
            5'd22:   v = 32'sd57;
            5'd23:   v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/occ_cmd_if.sv =====
// ----------------------------------------------------------------------------
// occ_cmd_if: command channel
// One word carries an operation code, an offset and a two-axis stick value.
// ----------------------------------------------------------------------------
interface occ_cmd_if import occ_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [STICK_W-1:0]  stick_x;
    logic signed [STICK_W-1:0]  stick_y;

    modport source (output valid, func, offset, stick_x, stick_y, input ready);
    modport sink   (input valid, func, offset, stick_x, stick_y, output ready);
endinterface

// ===== sv/occ_res_if.sv =====
// ----------------------------------------------------------------------------
// occ_res_if: result channel
// One word carries the whole camera state after a command.
// ----------------------------------------------------------------------------
interface occ_res_if import occ_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [YAW_W-1:0]    yaw_now;
    logic signed [PITCH_W-1:0]  pitch_now;
    logic [DIST_W-1:0]          distance_now;
    logic signed [FOCUS_W-1:0]  focus_x_now;
    logic signed [FOCUS_W-1:0]  focus_y_now;

    modport source (output valid, yaw_now, pitch_now, distance_now, focus_x_now,
                    focus_y_now, input ready);
    modport sink   (input valid, yaw_now, pitch_now, distance_now, focus_x_now,
                    focus_y_now, output ready);
endinterface

// ===== sv/orbit_camera_controller.sv =====
// ----------------------------------------------------------------------------
// orbit_camera_controller: orbit camera state machine
// Keeps yaw, pitch, distance and a ground focus point; applies spin, rise,
// zoom or move per command word and returns the whole state per word.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word
//  i_cmd     in   valid/ready    func, offset, stick_x, stick_y
//  o_res     out  valid/ready    yaw_now, pitch_now, distance_now, focus_x/y_now
//  i_cfg_*   in   write enable   dead_zone (index 0), move_gain (index 1)
//
// Spin, rise and zoom update the camera state in the accept cycle; the done
// state then loads their result into the output register once it is free.
// Move runs a 15-step sequence on one shared 33x33 signed multiplier (gain x
// distance, then per axis a^2, a^3 and two partial products of the scale, then
// four rotation products), with a CORDIC of TRIG_ITERATIONS steps running
// alongside; the rotation steps wait until the CORDIC is done.
// i_cmd.ready is high only while idle. A finished result waits in its own
// register, so a new word may be taken while o_res is stalled; the next result
// then waits until that register is free. Reset (synchronous, active low)
// zeroes the camera state and restores the register defaults.
// ----------------------------------------------------------------------------
module orbit_camera_controller import occ_pkg::*; #(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    occ_cmd_if.sink          i_cmd,
    occ_res_if.source        o_res,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOVE = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // move steps: one multiplier issue per step, none at SP_Y_END and SP_ROT_END
    localparam logic [3:0] SP_SCALE   = 4'd0;
    localparam logic [3:0] SP_X_SQ    = 4'd1;
    localparam logic [3:0] SP_X_CUBE  = 4'd2;
    localparam logic [3:0] SP_X_LO    = 4'd3;
    localparam logic [3:0] SP_X_HI    = 4'd4;
    localparam logic [3:0] SP_Y_SQ    = 4'd5;
    localparam logic [3:0] SP_Y_CUBE  = 4'd6;
    localparam logic [3:0] SP_Y_LO    = 4'd7;
    localparam logic [3:0] SP_Y_HI    = 4'd8;
    localparam logic [3:0] SP_Y_END   = 4'd9;
    localparam logic [3:0] SP_ROT_CX  = 4'd10;
    localparam logic [3:0] SP_ROT_SY  = 4'd11;
    localparam logic [3:0] SP_ROT_CY  = 4'd12;
    localparam logic [3:0] SP_ROT_SX  = 4'd13;
    localparam logic [3:0] SP_ROT_END = 4'd14;

    localparam logic [47:0] CUBE_ONE = 48'h0400_0000_0000;   // 1.0 in Q.42
    localparam logic [47:0] CUBE_RND = 48'h0000_0200_0000;   // half LSB of Q.16
    localparam logic [61:0] P_RND    = 62'h0000_0000_8000_0000;

    // config
    logic [DZ_W-1:0]   r_dead_zone;
    logic [GAIN_W-1:0] r_move_gain;

    // camera state
    logic signed [YAW_W-1:0]   r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;
    logic [DIST_W-1:0]         r_dist;
    logic signed [FOCUS_W-1:0] r_focus_x, r_focus_y;

    // sequencer
    logic [1:0] r_state;
    logic [3:0] r_step;

    // move datapath
    logic signed [STICK_W-1:0] r_sx, r_sy;
    logic signed [65:0]        r_prod;
    logic [39:0]               r_scale;
    logic [20:0]               r_m16;
    logic [40:0]               r_plo;
    logic signed [30:0]        r_dx, r_dy;
    logic signed [47:0]        r_acc;

    // output register
    logic                      r_ovalid;
    logic signed [YAW_W-1:0]   r_o_yaw;
    logic signed [PITCH_W-1:0] r_o_pitch;
    logic [DIST_W-1:0]         r_o_dist;
    logic signed [FOCUS_W-1:0] r_o_fx, r_o_fy;

    logic  cmd_acc, trig_start, out_free;
    t_trig trig;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign trig_start  = cmd_acc && (i_cmd.func == OP_MOVE);
    assign out_free    = !r_ovalid || o_res.ready;

    occ_cordic #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_yaw   (r_yaw),
        .o_trig  (trig)
    );

    // spin / rise / zoom
    logic signed [25:0] yaw_sum, yaw_wrap, yaw_new;
    logic signed [25:0] pitch_sum, pitch_new;
    logic signed [25:0] dist_sum, dist_new;

    always_comb begin
        yaw_sum  = 26'(r_yaw) + 26'(i_cmd.offset);
        yaw_wrap = yaw_sum;
        if (yaw_sum > 26'(HALF_TURN)) begin
            yaw_wrap = yaw_sum - 26'(FULL_TURN);
        end else if (yaw_sum < -26'(HALF_TURN)) begin
            yaw_wrap = yaw_sum + 26'(FULL_TURN);
        end
        // a huge offset still leaves it out of range after one wrap
        yaw_new = yaw_wrap;
        if (yaw_wrap > 26'(HALF_TURN)) begin
            yaw_new = 26'(HALF_TURN);
        end else if (yaw_wrap < -26'(HALF_TURN)) begin
            yaw_new = -26'(HALF_TURN);
        end

        pitch_sum = 26'(r_pitch) + 26'(i_cmd.offset);
        pitch_new = pitch_sum;
        if (pitch_sum > 26'sd0) begin
            pitch_new = 26'sd0;
        end else if (pitch_sum < 26'(PITCH_LOW)) begin
            pitch_new = 26'(PITCH_LOW);
        end

        dist_sum = $signed({2'b00, r_dist}) + 26'(i_cmd.offset);
        dist_new = dist_sum;
        if (dist_sum < 26'sd0) begin
            dist_new = 26'sd0;
        end else if (dist_sum > 26'(DIST_MAX)) begin
            dist_new = 26'(DIST_MAX);
        end
    end

    // stick shaping: magnitude, dead zone, a = |v| - dz + 1.0
    logic [16:0] mag_x, mag_y;
    logic        dead_x, dead_y, axis_y;
    logic [15:0] a_x, a_y, a_sel;
    logic [16:0] dz_ext;

    always_comb begin
        dz_ext = {2'b00, r_dead_zone};
        mag_x  = r_sx[STICK_W-1] ? 17'(-17'(r_sx)) : 17'(r_sx);
        mag_y  = r_sy[STICK_W-1] ? 17'(-17'(r_sy)) : 17'(r_sy);
        dead_x = mag_x < dz_ext;
        dead_y = mag_y < dz_ext;
        a_x    = 16'(mag_x - dz_ext + 17'd16384);
        a_y    = 16'(mag_y - dz_ext + 17'd16384);
        axis_y = (r_step >= SP_Y_SQ);
        a_sel  = axis_y ? a_y : a_x;
    end

    // cube -> Q.16 curve value, then rounded scaled delta
    logic [47:0]        cube_adj;
    logic [20:0]        m16;
    logic [61:0]        p_sum;
    logic [29:0]        p_mag;
    logic signed [30:0] d_x, d_y;

    always_comb begin
        cube_adj = 48'(r_prod[46:0]) - CUBE_ONE + CUBE_RND;
        m16      = cube_adj[46:26];
        p_sum    = {r_prod[41:0], 20'b0} + 62'(r_plo) + P_RND;
        p_mag    = p_sum[61:32];
        d_x      = dead_x ? 31'sd0 : (r_sx[STICK_W-1] ? -$signed({1'b0, p_mag})
                                                      : $signed({1'b0, p_mag}));
        d_y      = dead_y ? 31'sd0 : (r_sy[STICK_W-1] ? -$signed({1'b0, p_mag})
                                                      : $signed({1'b0, p_mag}));
    end

    // shared multiplier operand select
    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] c_ext, s_ext, dx_ext, dy_ext;

    assign c_ext  = 33'(trig.cos_q16);
    assign s_ext  = 33'(trig.sin_q16);
    assign dx_ext = 33'(r_dx);
    assign dy_ext = 33'(r_dy);

    always_comb begin
        case (r_step)
            SP_SCALE: begin
                mul_a = $signed({17'b0, r_move_gain});
                mul_b = $signed({9'b0, r_dist});
            end
            SP_X_SQ, SP_Y_SQ: begin
                mul_a = $signed({17'b0, a_sel});
                mul_b = $signed({17'b0, a_sel});
            end
            SP_X_CUBE, SP_Y_CUBE: begin
                mul_a = $signed({1'b0, r_prod[31:0]});
                mul_b = $signed({17'b0, a_sel});
            end
            SP_X_LO, SP_Y_LO: begin
                mul_a = $signed({12'b0, m16});
                mul_b = $signed({13'b0, r_scale[19:0]});
            end
            SP_X_HI, SP_Y_HI: begin
                mul_a = $signed({12'b0, r_m16});
                mul_b = $signed({13'b0, r_scale[39:20]});
            end
            SP_ROT_CX: begin
                mul_a = c_ext;
                mul_b = dx_ext;
            end
            SP_ROT_SY: begin
                mul_a = s_ext;
                mul_b = dy_ext;
            end
            SP_ROT_CY: begin
                mul_a = c_ext;
                mul_b = dy_ext;
            end
            SP_ROT_SX: begin
                mul_a = s_ext;
                mul_b = dx_ext;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // focus update: round off the Q.16 fraction of the rotated sum and saturate
    function automatic logic signed [FOCUS_W-1:0] focus_add(
        input logic signed [FOCUS_W-1:0] f,
        input logic signed [47:0]        sum
    );
        logic signed [47:0] rnd;
        logic signed [33:0] nf;
        rnd = sum + 48'sd32768;
        nf  = 34'(f) + 34'($signed(rnd[47:16]));
        if (nf > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (nf < -34'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end
        return nf[31:0];
    endfunction

    logic rot_stall;
    assign rot_stall = (r_step == SP_ROT_CX) && !trig.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_SCALE;
            r_dead_zone <= DEAD_ZONE_RST;
            r_move_gain <= MOVE_GAIN_RST;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_dist      <= '0;
            r_focus_x   <= '0;
            r_focus_y   <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_DEAD_ZONE: r_dead_zone <= i_cfg_wdata[DZ_W-1:0];
                    REG_MOVE_GAIN: r_move_gain <= i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // load a finished word, or drop the one just taken
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (cmd_acc) begin
                        case (i_cmd.func)
                            OP_SPIN: r_yaw   <= yaw_new[YAW_W-1:0];
                            OP_RISE: r_pitch <= pitch_new[PITCH_W-1:0];
                            OP_ZOOM: r_dist  <= dist_new[DIST_W-1:0];
                            default: ;
                        endcase
                        r_step  <= SP_SCALE;
                        r_state <= (i_cmd.func == OP_MOVE) ? ST_MOVE : ST_DONE;
                    end
                end
                ST_MOVE: begin
                    case (r_step)
                        SP_X_CUBE: ;
                        SP_Y_SQ:   r_dx <= d_x;
                        SP_Y_END:  r_dy <= d_y;
                        SP_ROT_CY: r_focus_x <= focus_add(r_focus_x,
                                                          r_acc + r_prod[47:0]);
                        SP_ROT_END: r_focus_y <= focus_add(r_focus_y,
                                                           r_acc - r_prod[47:0]);
                        default: ;
                    endcase
                    if (r_step == SP_ROT_END) begin
                        r_state <= ST_DONE;
                    end else if (!rot_stall) begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_sx <= i_cmd.stick_x;
            r_sy <= i_cmd.stick_y;
        end
        if (!rot_stall) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_step == SP_X_SQ) begin
            r_scale <= r_prod[39:0];
        end
        if (r_step == SP_X_LO || r_step == SP_Y_LO) begin
            r_m16 <= m16;
        end
        if (r_step == SP_X_HI || r_step == SP_Y_HI) begin
            r_plo <= r_prod[40:0];
        end
        if (r_step == SP_ROT_SY || r_step == SP_ROT_SX) begin
            r_acc <= r_prod[47:0];
        end
        if (r_state == ST_DONE && out_free) begin
            r_o_yaw   <= r_yaw;
            r_o_pitch <= r_pitch;
            r_o_dist  <= r_dist;
            r_o_fx    <= r_focus_x;
            r_o_fy    <= r_focus_y;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.yaw_now      = r_o_yaw;
    assign o_res.pitch_now    = r_o_pitch;
    assign o_res.distance_now = r_o_dist;
    assign o_res.focus_x_now  = r_o_fx;
    assign o_res.focus_y_now  = r_o_fy;

    // checks
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw <= 15'(HALF_TURN) && r_yaw >= -15'(HALF_TURN))
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pitch <= 14'sd0 && r_pitch >= 14'(PITCH_LOW))
        else $error("pitch out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> !i_cmd.ready)
        else $error("command taken while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid && $stable(o_res.focus_x_now))
        else $error("pending result overwritten");

endmodule

// ===== sv/occ_cordic.sv =====
// ----------------------------------------------------------------------------
// occ_cordic: iterative sine / cosine of the yaw angle
// One rotation step per cycle; result in Q.16 with the half-turn fold undone.
// ----------------------------------------------------------------------------
module occ_cordic import occ_pkg::*; #(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [YAW_W-1:0] i_yaw,
    output t_trig                   o_trig
);

    localparam int CW = $clog2(TRIG_ITERATIONS + 1);

    logic signed [33:0] r_x, r_y, n_x, n_y;
    logic signed [31:0] r_z, n_z;
    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_done, r_flip;

    logic signed [31:0] z0, z_fold, atan_v;
    logic               flip0;
    logic signed [33:0] fx, fy, cx, cy;

    // yaw to Q.22 degrees, folded into -90..90
    always_comb begin
        z0     = 32'(i_yaw) <<< ANG_Q22_SHIFT;
        z_fold = z0;
        flip0  = 1'b0;
        if (z0 > 32'(DEG_Q22_90)) begin
            z_fold = z0 - 32'(DEG_Q22_180);
            flip0  = 1'b1;
        end else if (z0 < -32'(DEG_Q22_90)) begin
            z_fold = z0 + 32'(DEG_Q22_180);
            flip0  = 1'b1;
        end
    end

    always_comb begin
        atan_v = atan_q22(5'(r_cnt));
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_cnt);
            n_y = r_y + (r_x >>> r_cnt);
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + (r_y >>> r_cnt);
            n_y = r_y - (r_x >>> r_cnt);
            n_z = r_z + atan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(TRIG_ITERATIONS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= 34'(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= flip0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign fx = r_flip ? -r_x : r_x;
    assign fy = r_flip ? -r_y : r_y;
    assign cx = fx + 34'sd8192;
    assign cy = fy + 34'sd8192;

    assign o_trig.done    = r_done;
    assign o_trig.cos_q16 = cx[31:14];
    assign o_trig.sin_q16 = cy[31:14];

endmodule
